@@ rtl/core/first_fit_unit_allocator_unit_defines.svh @@
// -----------------------------------------------------------------------------
// First-fit unit allocator: assertion macros
// Shared concurrent assertion shorthands for the allocator RTL.
// -----------------------------------------------------------------------------
`ifndef FIRST_FIT_UNIT_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_UNIT_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define FFUA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ffua: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define FFUA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ffua: next-cycle check failed");

`endif

@@ rtl/core/ffua_pkg.sv @@
// -----------------------------------------------------------------------------
// First-fit unit allocator package
// Pool geometry, field widths, codes and sequencer states.
// -----------------------------------------------------------------------------
package ffua_pkg;

    // Pool geometry
    localparam int UNIT_BYTES  = 16;
    localparam int POOL_BYTES  = 65536;
    localparam int UNITS       = POOL_BYTES / UNIT_BYTES;
    localparam int UNIT_W      = $clog2(UNITS);          // unit index
    localparam int UNIT_SH     = $clog2(UNIT_BYTES);     // byte <-> unit shift
    localparam int WORD_BITS   = 64;                     // bitmap word
    localparam int WORDS       = UNITS / WORD_BITS;
    localparam int WORD_W      = $clog2(WORDS);
    localparam int BIT_W       = $clog2(WORD_BITS);
    localparam int CNT_W       = BIT_W + 1;              // 0..64 count

    // Field widths
    localparam int ADDR_W      = 48;
    localparam int SIZE_W      = 32;
    localparam int LEN_W       = 13;
    localparam int BYTES_W     = 17;
    localparam int STATUS_W    = 2;
    localparam int IN_DATA_W   = SIZE_W + ADDR_W;
    localparam int OUT_DATA_W  = STATUS_W + ADDR_W + LEN_W + BYTES_W;

    // Sized constants
    localparam logic [LEN_W-1:0]   UNITS_CNT    = LEN_W'(UNITS);
    localparam logic [BYTES_W:0]   POOL_LIMIT   = (BYTES_W + 1)'(POOL_BYTES);
    localparam logic [ADDR_W-1:0]  BASE_RESET   = ADDR_W'(65536);

    typedef enum logic
    {
        OP_RESERVE = 1'b0,
        OP_RELEASE = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0]
    {
        STATUS_OK        = 2'd0,
        STATUS_EXHAUSTED = 2'd1,
        STATUS_INVALID   = 2'd2
    } status_t;

    typedef enum logic [3:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_SCAN_WAIT,
        ST_SCAN,
        ST_CHECK,
        ST_LEN_WAIT,
        ST_LEN_CHECK,
        ST_MARK_WAIT,
        ST_MARK_WR,
        ST_FINISH
    } state_t;

endpackage

@@ rtl/core/ffua_ram.sv @@
// -----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// -----------------------------------------------------------------------------
module ffua_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ rtl/core/first_fit_unit_allocator_unit.sv @@
// -----------------------------------------------------------------------------
// First-fit unit allocator
// Reserves and releases runs of 16-byte units from a 64 KiB pool.
// -----------------------------------------------------------------------------
//  channel  | dir | handshake             | payload
//  ---------+-----+-----------------------+--------------------------------------
//  s_axis   | in  | tvalid/tready         | tuser: op; tdata: size, address
//  m_axis   | out | tvalid/tready         | tdata: status, grant, live, bytes
//  cfg      | in  | cfg_wr_en (no wait)   | cfg_wr_data: pool_base
//
//  After reset a clearing pass zeroes the length table and the used bitmap;
//  s_axis_tready stays low until it ends.
//  A reserve scans the bitmap one 64-bit word at a time; in the scan state the
//  shared segment counter measures one free or used segment of the word each
//  cycle, after a wait state per word read, then marks each touched word.
//  A release checks the block length, then clears each touched bitmap word.
//  One beat is in flight at a time; the result register lets the next beat in
//  while the last result waits for m_axis_tready.
// -----------------------------------------------------------------------------
`include "first_fit_unit_allocator_unit_defines.svh"

module first_fit_unit_allocator_unit
    import ffua_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_wr_en,
    input  logic [ADDR_W-1:0]     cfg_wr_data,     // pool_base

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,    // size_bytes[31:0], block_address[79:32]
    input  logic [0:0]            s_axis_tuser,    // op[0]

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata     // status[1:0], granted_address[49:2],
                                                   // live_blocks[62:50], bytes_in_use[79:63]
);

    // Registers
    state_t                  state_reg, state_next;
    logic [UNIT_W-1:0]       clear_idx_reg, clear_idx_next;
    logic [ADDR_W-1:0]       pool_base_reg, pool_base_next;
    op_t                     op_reg, op_next;
    logic [SIZE_W-1:0]       size_reg, size_next;
    logic [ADDR_W-1:0]       addr_reg, addr_next;
    logic [LEN_W-1:0]        needed_reg, needed_next;
    logic [WORD_W-1:0]       word_reg, word_next;
    logic [BIT_W-1:0]        bit_reg, bit_next;
    logic [LEN_W-1:0]        run_reg, run_next;
    logic [UNIT_W-1:0]       run_start_reg, run_start_next;
    logic [UNIT_W-1:0]       start_reg, start_next;
    logic [UNIT_W-1:0]       last_reg, last_next;
    logic                    set_mode_reg, set_mode_next;
    status_t                 status_reg, status_next;
    logic [LEN_W-1:0]        live_count_reg, live_count_next;
    logic [BYTES_W-1:0]      used_bytes_reg, used_bytes_next;
    logic                    out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0]   out_data_reg, out_data_next;

    // Memory ports
    logic                    map_wr_en;
    logic [WORD_W-1:0]       map_wr_addr;
    logic [WORD_BITS-1:0]    map_wr_data;
    logic [WORD_BITS-1:0]    map_rd_data;
    logic                    len_wr_en;
    logic [UNIT_W-1:0]       len_wr_addr;
    logic [LEN_W-1:0]        len_wr_data;
    logic [LEN_W-1:0]        len_rd_data;

    // Datapath helpers
    logic [SIZE_W-1:0]       in_size;
    logic [ADDR_W-1:0]       in_addr;
    logic                    size_too_big;
    logic [BYTES_W-1:0]      size_m1;
    logic [ADDR_W:0]         rel_diff;
    logic                    cur_free;
    logic [2*WORD_BITS-1:0]  seg_shift;
    logic [WORD_BITS-1:0]    seg_bits;
    logic [CNT_W-1:0]        seg_cnt;
    logic [CNT_W-1:0]        seg_end;
    logic [LEN_W-1:0]        run_sum;
    logic [BYTES_W-1:0]      aligned;
    logic [BYTES_W:0]        used_sum;
    logic [BYTES_W-1:0]      rel_bytes;
    logic [LEN_W-1:0]        room;
    logic [BIT_W-1:0]        mask_lo;
    logic [BIT_W-1:0]        mask_hi;
    logic [WORD_BITS-1:0]    mark_mask;
    logic [ADDR_W-1:0]       grant;
    logic                    out_load;
    logic                    reserve_commit;

    // Length of the run of ones at the bottom of a word
    function automatic logic [CNT_W-1:0] trailing_ones(input logic [WORD_BITS-1:0] x);
        logic [CNT_W-1:0] n;
        n = CNT_W'(WORD_BITS);
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!x[i])
            begin
                n = CNT_W'(i);
            end
        end
        return n;
    endfunction

    // Used bitmap: one 64-bit word per entry
    ffua_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORDS)
    ) u_map_ram (
        .clk     (clk),
        .wr_en   (map_wr_en),
        .wr_addr (map_wr_addr),
        .wr_data (map_wr_data),
        .rd_addr (word_reg),
        .rd_data (map_rd_data)
    );

    // Block length table, indexed by start unit
    ffua_ram #(
        .WIDTH (LEN_W),
        .DEPTH (UNITS)
    ) u_len_ram (
        .clk     (clk),
        .wr_en   (len_wr_en),
        .wr_addr (len_wr_addr),
        .wr_data (len_wr_data),
        .rd_addr (start_reg),
        .rd_data (len_rd_data)
    );

    // Input unpack
    assign in_size = s_axis_tdata[SIZE_W-1:0];
    assign in_addr = s_axis_tdata[IN_DATA_W-1:SIZE_W];

    // Reserve sizing
    assign size_too_big = (size_reg[SIZE_W-1:BYTES_W] != '0) ||
                          (size_reg[BYTES_W-1] && (size_reg[BYTES_W-2:0] != '0));
    assign size_m1      = size_reg[BYTES_W-1:0] - BYTES_W'(1);

    // Release offset: borrow bit flags an address below the base
    assign rel_diff = {1'b0, addr_reg} - {1'b0, pool_base_reg};

    // Shared segment counter: length of the free or used run from the cursor
    assign cur_free  = ~map_rd_data[bit_reg];
    assign seg_shift = {{WORD_BITS{~cur_free}}, ~map_rd_data} >> bit_reg;
    assign seg_bits  = cur_free ? seg_shift[WORD_BITS-1:0] : ~seg_shift[WORD_BITS-1:0];
    assign seg_cnt   = trailing_ones(seg_bits);
    assign seg_end   = {1'b0, bit_reg} + seg_cnt;
    assign run_sum   = run_reg + LEN_W'(seg_cnt);

    // Counter checks
    assign aligned   = {needed_reg, UNIT_SH'(0)};
    assign used_sum  = {1'b0, used_bytes_reg} + {1'b0, aligned};
    assign rel_bytes = {len_rd_data, UNIT_SH'(0)};
    assign room      = UNITS_CNT - {1'b0, start_reg};

    // Mark mask for the current bitmap word
    assign mask_lo   = (word_reg == start_reg[UNIT_W-1:BIT_W]) ? start_reg[BIT_W-1:0] : '0;
    assign mask_hi   = (word_reg == last_reg[UNIT_W-1:BIT_W]) ? last_reg[BIT_W-1:0] : '1;
    assign mark_mask = ({WORD_BITS{1'b1}} << mask_lo) &
                       ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - mask_hi));

    // Granted address wraps in 48 bits
    assign grant = pool_base_reg + {{(ADDR_W - UNIT_W - UNIT_SH){1'b0}}, start_reg,
                                    UNIT_SH'(0)};

    assign out_load = (state_reg == ST_FINISH) && (!out_valid_reg || m_axis_tready);

    // Handshake outputs
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Sequencer: next state, datapath and memory writes
    always_comb
    begin
        state_next      = state_reg;
        clear_idx_next  = clear_idx_reg;
        pool_base_next  = cfg_wr_en ? cfg_wr_data : pool_base_reg;
        op_next         = op_reg;
        size_next       = size_reg;
        addr_next       = addr_reg;
        needed_next     = needed_reg;
        word_next       = word_reg;
        bit_next        = bit_reg;
        run_next        = run_reg;
        run_start_next  = run_start_reg;
        start_next      = start_reg;
        last_next       = last_reg;
        set_mode_next   = set_mode_reg;
        status_next     = status_reg;
        live_count_next = live_count_reg;
        used_bytes_next = used_bytes_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_data_next   = out_data_reg;
        reserve_commit  = 1'b0;

        map_wr_en   = 1'b0;
        map_wr_addr = word_reg;
        map_wr_data = set_mode_reg ? (map_rd_data | mark_mask) : (map_rd_data & ~mark_mask);
        len_wr_en   = 1'b0;
        len_wr_addr = start_reg;
        len_wr_data = '0;

        unique case (state_reg)
            // Zero both tables after reset
            ST_CLEAR:
            begin
                map_wr_en      = 1'b1;
                map_wr_addr    = clear_idx_reg[WORD_W-1:0];
                map_wr_data    = '0;
                len_wr_en      = 1'b1;
                len_wr_addr    = clear_idx_reg;
                clear_idx_next = clear_idx_reg + UNIT_W'(1);
                if (clear_idx_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next    = op_t'(s_axis_tuser[0]);
                    size_next  = in_size;
                    addr_next  = in_addr;
                    state_next = ST_DECODE;
                end
            end

            // Size rounding or release address checks
            ST_DECODE:
            begin
                if (op_reg == OP_RESERVE)
                begin
                    if (size_too_big)
                    begin
                        status_next = STATUS_EXHAUSTED;
                        state_next  = ST_FINISH;
                    end
                    else
                    begin
                        needed_next = (size_reg == '0) ? LEN_W'(1)
                                                       : size_m1[BYTES_W-1:UNIT_SH] + LEN_W'(1);
                        word_next   = '0;
                        bit_next    = '0;
                        run_next    = '0;
                        state_next  = ST_SCAN_WAIT;
                    end
                end
                else if (addr_reg == '0)
                begin
                    status_next = STATUS_OK;
                    state_next  = ST_FINISH;
                end
                else if (rel_diff[ADDR_W] || (rel_diff[ADDR_W-1:BYTES_W-1] != '0) ||
                         (rel_diff[UNIT_SH-1:0] != '0))
                begin
                    status_next = STATUS_INVALID;
                    state_next  = ST_FINISH;
                end
                else
                begin
                    start_next = rel_diff[BYTES_W-2:UNIT_SH];
                    state_next = ST_LEN_WAIT;
                end
            end

            ST_SCAN_WAIT:
            begin
                state_next = ST_SCAN;
            end

            // One segment of the current word per cycle
            ST_SCAN:
            begin
                if (cur_free && (run_sum >= needed_reg))
                begin
                    start_next = (run_reg == '0) ? {word_reg, bit_reg} : run_start_reg;
                    state_next = ST_CHECK;
                end
                else
                begin
                    if (cur_free)
                    begin
                        run_next = run_sum;
                        if (run_reg == '0)
                        begin
                            run_start_next = {word_reg, bit_reg};
                        end
                    end
                    else
                    begin
                        run_next = '0;
                    end

                    if (seg_end[CNT_W-1])
                    begin
                        if (word_reg == '1)
                        begin
                            status_next = STATUS_EXHAUSTED;
                            state_next  = ST_FINISH;
                        end
                        else
                        begin
                            word_next  = word_reg + WORD_W'(1);
                            bit_next   = '0;
                            state_next = ST_SCAN_WAIT;
                        end
                    end
                    else
                    begin
                        bit_next = seg_end[BIT_W-1:0];
                    end
                end
            end

            // Counter checks, then commit the reservation
            ST_CHECK:
            begin
                if ((live_count_reg >= UNITS_CNT) || (used_sum > POOL_LIMIT))
                begin
                    status_next = STATUS_INVALID;
                    state_next  = ST_FINISH;
                end
                else
                begin
                    reserve_commit  = 1'b1;
                    len_wr_en       = 1'b1;
                    len_wr_data     = needed_reg;
                    live_count_next = live_count_reg + LEN_W'(1);
                    used_bytes_next = used_sum[BYTES_W-1:0];
                    last_next       = start_reg + needed_reg[UNIT_W-1:0] - UNIT_W'(1);
                    set_mode_next   = 1'b1;
                    word_next       = start_reg[UNIT_W-1:BIT_W];
                    status_next     = STATUS_OK;
                    state_next      = ST_MARK_WAIT;
                end
            end

            ST_LEN_WAIT:
            begin
                state_next = ST_LEN_CHECK;
            end

            // Block length checks, then commit the release
            ST_LEN_CHECK:
            begin
                if ((len_rd_data == '0) || (len_rd_data > room) || (live_count_reg == '0) ||
                    (used_bytes_reg < rel_bytes))
                begin
                    status_next = STATUS_INVALID;
                    state_next  = ST_FINISH;
                end
                else
                begin
                    len_wr_en       = 1'b1;
                    len_wr_data     = '0;
                    live_count_next = live_count_reg - LEN_W'(1);
                    used_bytes_next = used_bytes_reg - rel_bytes;
                    last_next       = start_reg + len_rd_data[UNIT_W-1:0] - UNIT_W'(1);
                    set_mode_next   = 1'b0;
                    word_next       = start_reg[UNIT_W-1:BIT_W];
                    status_next     = STATUS_OK;
                    state_next      = ST_MARK_WAIT;
                end
            end

            ST_MARK_WAIT:
            begin
                state_next = ST_MARK_WR;
            end

            // Read-modify-write of one bitmap word
            ST_MARK_WR:
            begin
                map_wr_en = 1'b1;
                if (word_reg == last_reg[UNIT_W-1:BIT_W])
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    word_next  = word_reg + WORD_W'(1);
                    state_next = ST_MARK_WAIT;
                end
            end

            // Load the result register once it is free or its result is taken
            ST_FINISH:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {used_bytes_reg, live_count_reg,
                                      ((op_reg == OP_RESERVE) && (status_reg == STATUS_OK))
                                          ? grant : ADDR_W'(0),
                                      status_reg};
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clear_idx_reg  <= '0;
            pool_base_reg  <= BASE_RESET;
            live_count_reg <= '0;
            used_bytes_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clear_idx_reg  <= clear_idx_next;
            pool_base_reg  <= pool_base_next;
            live_count_reg <= live_count_next;
            used_bytes_reg <= used_bytes_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload and scan registers
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        size_reg      <= size_next;
        addr_reg      <= addr_next;
        needed_reg    <= needed_next;
        word_reg      <= word_next;
        bit_reg       <= bit_next;
        run_reg       <= run_next;
        run_start_reg <= run_start_next;
        start_reg     <= start_next;
        last_reg      <= last_next;
        set_mode_reg  <= set_mode_next;
        status_reg    <= status_next;
        out_data_reg  <= out_data_next;
    end

    // Checks
    `FFUA_ASSERT_NOW(a_counts_agree, clk, rst_n, (live_count_reg == '0), (used_bytes_reg == '0))
    `FFUA_ASSERT_NOW(a_bytes_in_pool, clk, rst_n, 1'b1, ({1'b0, used_bytes_reg} <= POOL_LIMIT))
    `FFUA_ASSERT_NOW(a_no_accept_in_clear, clk, rst_n, (state_reg == ST_CLEAR), !s_axis_tready)
    `FFUA_ASSERT_NEXT(a_live_inc, clk, rst_n, reserve_commit, (live_count_reg == $past(live_count_reg) + LEN_W'(1)))

endmodule
